[hdl/path_repeat_vertex_mode_finder_assert.svh]
// assertion macros used by the rtl file prvm_back
// the enclosing module provides i_clk and i_rst_n
`ifndef PATH_REPEAT_VERTEX_MODE_FINDER_ASSERT_SVH
`define PATH_REPEAT_VERTEX_MODE_FINDER_ASSERT_SVH

`ifndef SYNTH

// expression holds at every clock edge out of reset
`define PRVM_ASSERT(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("prvm check failed");

// consequent holds in the cycle after the antecedent
`define PRVM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("prvm check failed");

`else

`define PRVM_ASSERT(label, expr)
`define PRVM_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[hdl/prvm_pkg.sv]
package prvm_pkg;

    // default sizes
    localparam int VERTEX_COUNT_DEF = 256;
    localparam int COUNT_BITS_DEF   = 16;

    // path tag width of the per-vertex bitmap entries
    localparam int EPOCH_BITS = 8;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = 2;

    // register indexes and reset values
    localparam logic [7:0]  CFG_COST_THRESHOLD = 8'd0;
    localparam logic [7:0]  CFG_DEPOT_VERTEX   = 8'd1;
    localparam logic [15:0] COST_THRESHOLD_RST = 16'd66;
    localparam logic [7:0]  DEPOT_VERTEX_RST   = 8'd0;

    // largest multiplicity the result can carry
    localparam logic [15:0] BEST_COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [7:0]         vertex;
        logic signed [31:0] path_cost;
        logic               path_end;
        logic               batch_end;
    } t_in_item;

    typedef struct packed {
        logic        found;
        logic [7:0]  best_vertex;
        logic [15:0] best_count;
    } t_out_item;

    // classified item handed from front to back
    typedef struct packed {
        logic [7:0] vertex;
        logic       count_en;
        logic       close;
        logic       batch_end;
    } t_queue_item;

endpackage

[hdl/path_repeat_vertex_mode_finder.sv]
// channel   dir   signals                                  transfer when
// in        in    i_in_valid  o_in_ready  i_in_data        valid & ready
// out       out   o_out_valid i_out_ready o_out_data       valid & ready
// cfg       in    i_cfg_valid o_cfg_ready i_cfg_index/data valid & ready
//
// a counted vertex reads its entry, then writes it back as needed; other items need no entry access
// end of batch walks every vertex entry before the result is offered
// after reset a clearing pass over every vertex entry runs with o_in_ready low
// every 255 closed paths within a batch the path tags wrap: a sweep over every vertex entry
// the front keeps taking items into a 4 entry queue while the back is busy, until the queue is full;
// one result waits in the output register while the next batch is processed
module path_repeat_vertex_mode_finder #(
    parameter int VERTEX_COUNT = prvm_pkg::VERTEX_COUNT_DEF,
    parameter int COUNT_BITS   = prvm_pkg::COUNT_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  prvm_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output prvm_pkg::t_out_item o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [7:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);

    logic [15:0] r_cost_threshold;
    logic [7:0]  r_depot_vertex;

    logic                  push;
    prvm_pkg::t_queue_item push_data;
    logic                  queue_full;
    logic                  queue_valid;
    logic                  pop;
    prvm_pkg::t_queue_item queue_data;
    logic                  init_busy;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cost_threshold <= prvm_pkg::COST_THRESHOLD_RST;
            r_depot_vertex   <= prvm_pkg::DEPOT_VERTEX_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == prvm_pkg::CFG_COST_THRESHOLD) begin
                r_cost_threshold <= i_cfg_data;
            end else if (i_cfg_index == prvm_pkg::CFG_DEPOT_VERTEX) begin
                r_depot_vertex <= i_cfg_data[7:0];
            end
        end
    end

    prvm_front #(
        .VERTEX_COUNT(VERTEX_COUNT)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cost_threshold(r_cost_threshold),
        .i_depot_vertex  (r_depot_vertex),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_in_data       (i_in_data),
        .i_queue_full    (queue_full),
        .i_init_busy     (init_busy),
        .o_push          (push),
        .o_push_data     (push_data)
    );

    prvm_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (push_data),
        .o_full (queue_full),
        .o_valid(queue_valid),
        .i_pop  (pop),
        .o_data (queue_data)
    );

    prvm_back #(
        .VERTEX_COUNT(VERTEX_COUNT),
        .COUNT_BITS  (COUNT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item_valid(queue_valid),
        .i_item      (queue_data),
        .o_pop       (pop),
        .o_init_busy (init_busy),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

[hdl/prvm_queue.sv]
module prvm_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  prvm_pkg::t_queue_item i_data,
    output logic                  o_full,
    output logic                  o_valid,
    input  logic                  i_pop,
    output prvm_pkg::t_queue_item o_data
);

    prvm_pkg::t_queue_item r_buf [prvm_pkg::QUEUE_DEPTH];
    logic [prvm_pkg::QPTR_BITS-1:0] r_wr_ptr;
    logic [prvm_pkg::QPTR_BITS-1:0] r_rd_ptr;
    logic [prvm_pkg::QPTR_BITS:0]   r_fill;

    assign o_full  = (r_fill == (prvm_pkg::QPTR_BITS+1)'(prvm_pkg::QUEUE_DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_data  = r_buf[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (!i_push && i_pop) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_data;
        end
    end

endmodule

[hdl/prvm_front.sv]
module prvm_front #(
    parameter int VERTEX_COUNT = prvm_pkg::VERTEX_COUNT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [15:0]           i_cost_threshold,
    input  logic [7:0]            i_depot_vertex,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  prvm_pkg::t_in_item    i_in_data,
    input  logic                  i_queue_full,
    input  logic                  i_init_busy,
    output logic                  o_push,
    output prvm_pkg::t_queue_item o_push_data
);

    logic r_open;
    logic r_qual;
    logic r_stopped;
    logic n_open;
    logic n_qual;
    logic n_stopped;

    logic signed [32:0] w_cost;
    logic signed [32:0] w_neg_thr;
    logic               w_cost_ok;
    logic               w_qual_now;
    logic               w_active;
    logic               w_is_depot;
    logic               w_in_range;
    logic               w_close;
    logic               w_xfer;

    assign o_in_ready = !i_queue_full && !i_init_busy;
    assign w_xfer     = i_in_valid && o_in_ready;

    // first item of a path decides whether the path counts
    assign w_cost     = {i_in_data.path_cost[31], i_in_data.path_cost};
    assign w_neg_thr  = 33'sd0 - $signed({17'd0, i_cost_threshold});
    assign w_cost_ok  = (w_cost <= w_neg_thr);
    assign w_qual_now = r_open ? r_qual : w_cost_ok;

    // classify the vertex
    assign w_active   = w_qual_now && !r_stopped;
    assign w_is_depot = (i_in_data.vertex == i_depot_vertex);
    assign w_in_range = (32'(i_in_data.vertex) < 32'(VERTEX_COUNT));
    assign w_close    = i_in_data.path_end || i_in_data.batch_end;

    // only items that touch the back are queued
    always_comb begin
        o_push_data.vertex    = i_in_data.vertex;
        o_push_data.count_en  = w_active && !w_is_depot && w_in_range;
        o_push_data.close     = w_close;
        o_push_data.batch_end = i_in_data.batch_end;
        o_push = w_xfer && (o_push_data.count_en || w_close);
    end

    // path tracking
    always_comb begin
        if (w_close) begin
            n_open    = 1'b0;
            n_qual    = 1'b0;
            n_stopped = 1'b0;
        end else begin
            n_open    = 1'b1;
            n_qual    = w_qual_now;
            n_stopped = r_stopped || (w_active && w_is_depot);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open    <= 1'b0;
            r_qual    <= 1'b0;
            r_stopped <= 1'b0;
        end else if (w_xfer) begin
            r_open    <= n_open;
            r_qual    <= n_qual;
            r_stopped <= n_stopped;
        end
    end

endmodule

[hdl/prvm_back.sv]
`include "path_repeat_vertex_mode_finder_assert.svh"

module prvm_back #(
    parameter int VERTEX_COUNT = prvm_pkg::VERTEX_COUNT_DEF,
    parameter int COUNT_BITS   = prvm_pkg::COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_item_valid,
    input  prvm_pkg::t_queue_item i_item,
    output logic                  o_pop,
    output logic                  o_init_busy,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output prvm_pkg::t_out_item   o_out_data
);

    localparam int VIDX = $clog2(VERTEX_COUNT);
    localparam logic [VIDX-1:0] LAST_ADDR = VIDX'(VERTEX_COUNT - 1);
    localparam logic [prvm_pkg::EPOCH_BITS-1:0] FIRST_EPOCH = prvm_pkg::EPOCH_BITS'(1);

    // per-vertex entry: path tag, path bitmaps, batch multiplicity
    typedef struct packed {
        logic [prvm_pkg::EPOCH_BITS-1:0] epoch;
        logic                            seen;
        logic                            rep;
        logic [COUNT_BITS-1:0]           count;
    } t_entry;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_UPD,
        S_SCAN,
        S_DONE,
        S_WRAP
    } t_state;

    t_entry r_mem [VERTEX_COUNT];
    t_entry r_rdata;

    t_state                          r_state;
    t_state                          n_state;
    logic [prvm_pkg::EPOCH_BITS-1:0] r_epoch;
    logic [prvm_pkg::EPOCH_BITS-1:0] n_epoch;
    logic [VIDX-1:0]                 r_addr;
    logic [VIDX-1:0]                 n_addr;
    prvm_pkg::t_queue_item           r_item;
    prvm_pkg::t_queue_item           n_item;
    logic                            r_cmp_v;
    logic                            n_cmp_v;
    logic [VIDX-1:0]                 r_cmp_idx;
    logic [VIDX-1:0]                 n_cmp_idx;
    logic [COUNT_BITS-1:0]           r_best_cnt;
    logic [COUNT_BITS-1:0]           n_best_cnt;
    logic [VIDX-1:0]                 r_best_idx;
    logic [VIDX-1:0]                 n_best_idx;
    logic                            r_out_valid;
    logic                            n_out_valid;
    prvm_pkg::t_out_item             r_out;
    prvm_pkg::t_out_item             n_out;

    logic            mem_re;
    logic [VIDX-1:0] mem_raddr;
    logic            mem_we;
    logic [VIDX-1:0] mem_waddr;
    t_entry          mem_wdata;

    logic            fin;
    logic            fin_close;
    logic            fin_bend;
    logic            w_hit;
    logic            w_seen;
    logic            w_rep;
    logic [32:0]     w_best_ext;

    assign o_pop       = (r_state == S_IDLE) && i_item_valid;
    assign o_init_busy = (r_state == S_CLEAR);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // bitmap bits are live only under the current path tag
    assign w_hit      = (r_rdata.epoch == r_epoch);
    assign w_seen     = w_hit && r_rdata.seen;
    assign w_rep      = w_hit && r_rdata.rep;
    assign w_best_ext = 33'(r_best_cnt);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_epoch     = r_epoch;
        n_addr      = r_addr;
        n_item      = r_item;
        n_cmp_v     = 1'b0;
        n_cmp_idx   = r_addr;
        n_best_cnt  = r_best_cnt;
        n_best_idx  = r_best_idx;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        mem_re      = 1'b0;
        mem_raddr   = r_addr;
        mem_we      = 1'b0;
        mem_waddr   = r_addr;
        mem_wdata   = '0;
        fin         = 1'b0;
        fin_close   = 1'b0;
        fin_bend    = 1'b0;

        // argmax compare, in the cycle after the scan read
        if (r_cmp_v && (r_rdata.count > r_best_cnt)) begin
            n_best_cnt = r_rdata.count;
            n_best_idx = r_cmp_idx;
        end

        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                n_addr = r_addr + 1'b1;
                if (r_addr == LAST_ADDR) begin
                    n_addr  = '0;
                    n_epoch = FIRST_EPOCH;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_item_valid) begin
                    if (i_item.count_en) begin
                        mem_re    = 1'b1;
                        mem_raddr = VIDX'(i_item.vertex);
                        n_item    = i_item;
                        n_state   = S_UPD;
                    end else begin
                        fin       = 1'b1;
                        fin_close = i_item.close;
                        fin_bend  = i_item.batch_end;
                    end
                end
            end
            S_UPD: begin
                mem_waddr       = VIDX'(r_item.vertex);
                mem_wdata.epoch = r_epoch;
                mem_wdata.seen  = 1'b1;
                mem_wdata.rep   = w_seen;
                mem_wdata.count = r_rdata.count;
                if (!w_seen) begin
                    mem_we = 1'b1;
                end else if (!w_rep) begin
                    mem_we = 1'b1;
                    if (r_rdata.count != '1) begin
                        mem_wdata.count = r_rdata.count + 1'b1;
                    end
                end
                n_state   = S_IDLE;
                fin       = 1'b1;
                fin_close = r_item.close;
                fin_bend  = r_item.batch_end;
            end
            S_SCAN: begin
                // read old counter, clear the entry behind it
                mem_re    = 1'b1;
                mem_we    = 1'b1;
                n_cmp_v   = 1'b1;
                n_cmp_idx = r_addr;
                n_addr    = r_addr + 1'b1;
                if (r_addr == LAST_ADDR) begin
                    n_addr  = '0;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_cmp_v && (!r_out_valid || i_out_ready)) begin
                    n_out_valid = 1'b1;
                    if (r_best_idx == '0) begin
                        n_out = '0;
                    end else begin
                        n_out.found       = 1'b1;
                        n_out.best_vertex = 8'(r_best_idx);
                        n_out.best_count  = (w_best_ext > 33'(prvm_pkg::BEST_COUNT_MAX))
                                          ? prvm_pkg::BEST_COUNT_MAX : 16'(r_best_cnt);
                    end
                    n_epoch = FIRST_EPOCH;
                    n_state = S_IDLE;
                end
            end
            S_WRAP: begin
                // read each entry, write it back in the following cycle with tag and bitmaps cleared
                mem_re    = 1'b1;
                n_cmp_v   = 1'b1;
                n_cmp_idx = r_addr;
                n_addr    = r_addr + 1'b1;
                if (r_cmp_v) begin
                    mem_we          = 1'b1;
                    mem_waddr       = r_cmp_idx;
                    mem_wdata.count = r_rdata.count;
                    if (r_cmp_idx == LAST_ADDR) begin
                        mem_re  = 1'b0;
                        n_cmp_v = 1'b0;
                        n_addr  = '0;
                        n_epoch = FIRST_EPOCH;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_addr  = '0;
            end
        endcase

        // path and batch close
        if (fin) begin
            priority if (fin_bend) begin
                n_state    = S_SCAN;
                n_addr     = '0;
                n_best_cnt = '0;
                n_best_idx = '0;
            end else if (fin_close) begin
                if (r_epoch == '1) begin
                    n_state = S_WRAP;
                    n_addr  = '0;
                end else begin
                    n_epoch = r_epoch + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_epoch     <= FIRST_EPOCH;
            r_addr      <= '0;
            r_cmp_v     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_epoch     <= n_epoch;
            r_addr      <= n_addr;
            r_cmp_v     <= n_cmp_v;
            r_out_valid <= n_out_valid;
        end
        r_item     <= n_item;
        r_cmp_idx  <= n_cmp_idx;
        r_best_cnt <= n_best_cnt;
        r_best_idx <= n_best_idx;
        r_out      <= n_out;
    end

    // vertex entry memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    `PRVM_ASSERT(a_epoch_nonzero, r_epoch != '0)
    `PRVM_ASSERT_NEXT(a_upd_one_cycle, r_state == S_UPD, r_state != S_UPD)
    `PRVM_ASSERT(a_cmp_in_scan,
        !r_cmp_v || r_state == S_SCAN || r_state == S_DONE || r_state == S_WRAP)
    `PRVM_ASSERT(a_not_found_zero,
        !r_out_valid || r_out.found || (r_out.best_vertex == '0 && r_out.best_count == '0))

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    localparam int VERTICES      = prvm_pkg::VERTEX_COUNT_DEF;
    localparam int SETTLE_CYCLES = 2 * VERTICES + 88;
    localparam int HOLD_CYCLES   = 1500;
    localparam int STALL_LIMIT   = 5000;
    localparam int WRAP_PATHS    = 260;
    localparam int PHASE_ITEMS   = 60;
    localparam logic [7:0] CFG_UNMAPPED = 8'd2;

    // reference behavior and expected results of the vertex mode finder
    class mode_scoreboard;
        logic [15:0] thr;
        logic [7:0]  depot;
        bit [VERTICES-1:0] seen;
        bit [VERTICES-1:0] repeated;
        logic [15:0] mult [VERTICES];
        bit stopped;
        bit open;
        bit qual;
        prvm_pkg::t_out_item mode_q[$];
        int errors;
        int checked;

        function new();
            int i;
            thr     = prvm_pkg::COST_THRESHOLD_RST;
            depot   = prvm_pkg::DEPOT_VERTEX_RST;
            errors  = 0;
            checked = 0;
            for (i = 0; i < VERTICES; i++) mult[i] = '0;
            close_path();
        endfunction

        function void close_path();
            seen     = '0;
            repeated = '0;
            stopped  = 1'b0;
            open     = 1'b0;
            qual     = 1'b0;
        endfunction

        function void set_reg(logic [7:0] idx, logic [15:0] data);
            if (idx == prvm_pkg::CFG_COST_THRESHOLD) thr = data;
            else if (idx == prvm_pkg::CFG_DEPOT_VERTEX) depot = data[7:0];
        endfunction

        function int pending();
            return mode_q.size();
        endfunction

        // apply one accepted edge item, queue the batch result on batch end
        function void note_input(prvm_pkg::t_in_item it);
            longint    cost;
            longint    limit;
            logic [15:0] best;
            logic [7:0]  idx;
            prvm_pkg::t_out_item e;
            int i;
            if (!open) begin
                cost  = longint'($signed(it.path_cost));
                limit = longint'({48'b0, thr});
                open  = 1'b1;
                qual  = (cost <= -limit);
            end
            if (qual && !stopped) begin
                if (it.vertex == depot) begin
                    stopped = 1'b1;
                end else if (seen[it.vertex]) begin
                    if (!repeated[it.vertex]) begin
                        repeated[it.vertex] = 1'b1;
                        if (mult[it.vertex] != prvm_pkg::BEST_COUNT_MAX)
                            mult[it.vertex] = mult[it.vertex] + 16'd1;
                    end
                end else begin
                    seen[it.vertex] = 1'b1;
                end
            end
            if (it.path_end || it.batch_end) close_path();
            if (it.batch_end) begin
                best = '0;
                idx  = '0;
                for (i = 0; i < VERTICES; i++) begin
                    if (mult[i] > best) begin
                        best = mult[i];
                        idx  = i[7:0];
                    end
                end
                e.found       = (idx != 8'd0);
                e.best_vertex = e.found ? idx : 8'd0;
                e.best_count  = e.found ? best : 16'd0;
                mode_q = {mode_q, e};
                for (i = 0; i < VERTICES; i++) mult[i] = '0;
            end
        endfunction

        // compare one result transfer with the oldest expected result
        function void check_result(prvm_pkg::t_out_item got);
            prvm_pkg::t_out_item e;
            if (mode_q.size() == 0) begin
                $display("%0t: unexpected result found=%0b vertex=%0d count=%0d",
                         $time, got.found, got.best_vertex, got.best_count);
                errors++;
                return;
            end
            e = mode_q.pop_front();
            checked++;
            if (got.found !== e.found) begin
                $display("%0t: found expected %0b actual %0b", $time, e.found, got.found);
                errors++;
            end
            if (got.best_vertex !== e.best_vertex) begin
                $display("%0t: best_vertex expected %0d actual %0d",
                         $time, e.best_vertex, got.best_vertex);
                errors++;
            end
            if (got.best_count !== e.best_count) begin
                $display("%0t: best_count expected %0d actual %0d",
                         $time, e.best_count, got.best_count);
                errors++;
            end
        endfunction
    endclass

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_ready;
    prvm_pkg::t_in_item  i_in_data   = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    prvm_pkg::t_out_item o_out_data;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [7:0]          i_cfg_index = '0;
    logic [15:0]         i_cfg_data  = '0;

    mode_scoreboard sb = new();

    bit          hold_req  = 1'b0;
    int          holds     = 0;
    int          items_in  = 0;
    int          reg_writes = 0;
    int          batches   = 0;
    int          quiet     = 0;
    logic [15:0] cur_thr   = prvm_pkg::COST_THRESHOLD_RST;
    logic [7:0]  cur_depot = prvm_pkg::DEPOT_VERTEX_RST;

    path_repeat_vertex_mode_finder i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // transfer monitors
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                sb.note_input(i_in_data);
                items_in++;
            end
            if (o_out_valid && i_out_ready) sb.check_result(o_out_data);
        end
    end

    // stall watchdog
    initial begin
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready) || !i_rst_n)
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // random gap: mostly none or short, a few long
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // result side ready pattern, with the one long hold-off
    initial begin
        int gap;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
                holds++;
            end else begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                gap = idle_gap();
                if (gap > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    end

    // offer one edge item and wait for its transfer
    task automatic send_item(logic [7:0] v, logic [31:0] cost, bit pe, bit be);
        int gap;
        prvm_pkg::t_in_item it;
        gap = idle_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        it.vertex    = v;
        it.path_cost = cost;
        it.path_end  = pe;
        it.batch_end = be;
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        if (be) batches++;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // stop offering, wait out all results and the tail of internal work
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        sb.set_reg(idx, data);
        reg_writes++;
        if (idx == prvm_pkg::CFG_COST_THRESHOLD) cur_thr = data;
        else if (idx == prvm_pkg::CFG_DEPOT_VERTEX) cur_depot = data[7:0];
    endtask

    task automatic set_config(logic [15:0] thr, logic [7:0] depot);
        write_reg(prvm_pkg::CFG_COST_THRESHOLD, thr);
        write_reg(prvm_pkg::CFG_DEPOT_VERTEX, {8'($urandom_range(0, 255)), depot});
    endtask

    // vertex mostly from a narrow window so repeats happen
    function automatic logic [7:0] pick_vertex(logic [7:0] base);
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return base + 8'($urandom_range(0, 7));
        if (r < 8) return 8'($urandom_range(0, 255));
        if (r == 8) return cur_depot;
        return base;
    endfunction

    // cost of a path's first item: mostly qualifying, edges of the threshold, noise
    function automatic logic [31:0] pick_cost();
        int r;
        logic signed [31:0] neg_thr;
        neg_thr = 32'sd0 - $signed({16'h0, cur_thr});
        r = $urandom_range(0, 9);
        if (r < 6) return neg_thr - $signed(32'($urandom_range(0, 100000)));
        if (r == 6) return neg_thr;
        if (r == 7) return neg_thr + 32'sd1;
        return $urandom;
    endfunction

    task automatic random_phase(int n_items);
        int sent;
        int n_paths;
        int len;
        int p;
        int k;
        bit pe;
        bit be;
        logic [7:0] base;
        sent = 0;
        while (sent < n_items) begin
            n_paths = $urandom_range(1, 4);
            for (p = 0; p < n_paths; p++) begin
                len  = $urandom_range(1, 8);
                base = 8'($urandom_range(0, 248));
                for (k = 0; k < len; k++) begin
                    be = (p == n_paths - 1) && (k == len - 1);
                    pe = (k == len - 1) || ($urandom_range(0, 19) == 0);
                    if (be && $urandom_range(0, 3) == 0) pe = 1'b0;
                    send_item(pick_vertex(base), (k == 0) ? pick_cost() : $urandom, pe, be);
                    sent++;
                end
            end
        end
    endtask

    // main sequence
    initial begin
        int p;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: threshold edge, repeats, depot stop, cost of first item rules
        send_item(8'd5, -32'sd66, 1'b1, 1'b1);
        send_item(8'd3, -32'sd100000, 1'b0, 1'b0);
        send_item(8'd7, 32'h0000_0001, 1'b0, 1'b0);
        send_item(8'd3, 32'h0000_0001, 1'b0, 1'b0);
        send_item(8'd7, 32'h7FFF_FFFF, 1'b1, 1'b0);
        send_item(8'd7, -32'sd67, 1'b0, 1'b0);
        send_item(8'd7, 32'h7FFF_FFFF, 1'b1, 1'b0);
        send_item(8'd4, -32'sd66, 1'b0, 1'b0);
        send_item(8'd0, -32'sd1, 1'b0, 1'b0);
        send_item(8'd4, -32'sd1, 1'b0, 1'b0);
        send_item(8'd4, -32'sd1, 1'b1, 1'b0);
        send_item(8'd8, -32'sd65, 1'b0, 1'b0);
        send_item(8'd8, -32'sd100000, 1'b1, 1'b0);
        send_item(8'd9, 32'h7FFF_FFFF, 1'b0, 1'b1);
        drain();

        // zero threshold, top depot: vertex zero winning, batch end closing a path, ties
        set_config(16'd0, 8'd255);
        send_item(8'd0, 32'h0000_0000, 1'b0, 1'b0);
        send_item(8'd0, 32'h0000_0000, 1'b0, 1'b0);
        send_item(8'd255, 32'h0000_0000, 1'b0, 1'b0);
        send_item(8'd1, 32'h0000_0000, 1'b0, 1'b0);
        send_item(8'd1, 32'h0000_0000, 1'b1, 1'b0);
        send_item(8'd1, 32'h8000_0000, 1'b0, 1'b0);
        send_item(8'd0, 32'h0000_0000, 1'b0, 1'b0);
        send_item(8'd1, 32'h0000_0000, 1'b0, 1'b0);
        send_item(8'd0, 32'h0000_0000, 1'b0, 1'b1);
        send_item(8'd200, -32'sd1, 1'b0, 1'b0);
        send_item(8'd200, -32'sd1, 1'b1, 1'b0);
        send_item(8'd201, -32'sd1, 1'b0, 1'b0);
        send_item(8'd201, -32'sd1, 1'b1, 1'b1);
        drain();

        // largest threshold on both sides of its edge
        set_config(16'hFFFF, 8'd0);
        send_item(8'd10, 32'hFFFF_0001, 1'b0, 1'b0);
        send_item(8'd10, 32'hFFFF_0001, 1'b1, 1'b0);
        send_item(8'd11, 32'hFFFF_0002, 1'b0, 1'b0);
        send_item(8'd11, 32'hFFFF_0002, 1'b1, 1'b1);
        drain();
        write_reg(CFG_UNMAPPED, 16'hA5A5);

        // one batch with enough closed paths to wrap the path tags, repeats on both sides
        set_config(prvm_pkg::COST_THRESHOLD_RST, 8'd0);
        send_item(8'd20, -32'sd100, 1'b0, 1'b0);
        send_item(8'd20, -32'sd100, 1'b1, 1'b0);
        for (p = 0; p < WRAP_PATHS; p++) begin
            send_item(8'd20, -32'sd100, 1'b1, 1'b0);
        end
        send_item(8'd20, -32'sd100, 1'b0, 1'b0);
        send_item(8'd20, -32'sd100, 1'b1, 1'b1);
        drain();

        // random batches under several settings, one with the output held off
        set_config(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
        random_phase(PHASE_ITEMS);
        drain();
        set_config(16'hFFFF, 8'd255);
        hold_req = 1'b1;
        random_phase(PHASE_ITEMS);
        drain();
        set_config(16'd0, 8'd0);
        random_phase(PHASE_ITEMS);
        drain();
        set_config(16'($urandom_range(0, 200)), 8'($urandom_range(0, 255)));
        random_phase(PHASE_ITEMS);
        drain();

        if (sb.pending() > 0) begin
            $display("%0t: %0d expected results never arrived", $time, sb.pending());
            sb.errors++;
        end
        $display("%0d edge items in %0d batches, %0d results compared, %0d register writes",
                 items_in, batches, sb.checked, reg_writes);
        $display("covered threshold and depot extremes, a path tag wrap, %0d output hold-off",
                 holds);
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+hdl
hdl/prvm_pkg.sv
hdl/prvm_queue.sv
hdl/prvm_front.sv
hdl/prvm_back.sv
hdl/path_repeat_vertex_mode_finder.sv
sim/tb_top.sv
